### rtl/mqim_pkg.sv
// ----------------------------------------------------------------------------
// mqim_pkg
// Shared sizes, codes and types of the multi-queue id manager.
// ----------------------------------------------------------------------------
package mqim_pkg;

	// storage shape
	localparam int NUM_QUEUES  = 3;
	localparam int QUEUE_DEPTH = 64;
	localparam int ID_BITS     = 22;

	// fixed field widths of the channels
	localparam int OP_W    = 2;
	localparam int IDENT_W = 22;
	localparam int QSEL_W  = 2;
	localparam int STAT_W  = 2;
	localparam int POS_W   = 6;
	localparam int LEN_W   = 7;

	// derived internal widths
	localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int PIDX_W = $clog2(QUEUE_DEPTH);

	// operation codes
	localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
	localparam logic [OP_W-1:0] OP_REM  = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BADQ    = 2'd3;

	// per-cell command from the controller
	typedef struct packed {
		logic [QIDX_W-1:0]  q;
		logic [ID_BITS-1:0] id;
		logic               load;
		logic               shift;
	} mqim_cell_cmd_t;

endpackage

### rtl/mqim_cmd_if.sv
// ----------------------------------------------------------------------------
// mqim_cmd_if
// Command channel: valid/ready handshake with operation, id and queue number.
// ----------------------------------------------------------------------------
interface mqim_cmd_if import mqim_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [IDENT_W-1:0] ident;
	logic [QSEL_W-1:0]  queue_sel;

	modport source (output valid, output operation, output ident, output queue_sel,
		input ready);
	modport sink (input valid, input operation, input ident, input queue_sel,
		output ready);
endinterface

### rtl/mqim_res_if.sv
// ----------------------------------------------------------------------------
// mqim_res_if
// Result channel: valid/ready handshake with status and lookup fields.
// ----------------------------------------------------------------------------
interface mqim_res_if import mqim_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic              found;
	logic [POS_W-1:0]  position;
	logic              at_head;
	logic [LEN_W-1:0]  queue_length;

	modport source (output valid, output status, output found, output position,
		output at_head, output queue_length, input ready);
	modport sink (input valid, input status, input found, input position,
		input at_head, input queue_length, output ready);
endinterface

### rtl/mqim_cell.sv
// ----------------------------------------------------------------------------
// mqim_cell
// One slot position of every queue: stores, compares and shifts toward head.
// ----------------------------------------------------------------------------
module mqim_cell import mqim_pkg::*; (
	input  logic               clk,
	input  mqim_cell_cmd_t     cmd,
	input  logic [ID_BITS-1:0] nb_data,
	output logic [ID_BITS-1:0] data,
	output logic               match
);

	logic [ID_BITS-1:0] slot_q [NUM_QUEUES];

	// slot of the selected queue goes to the left neighbor
	assign data  = slot_q[cmd.q];
	assign match = (slot_q[cmd.q] == cmd.id);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_q[cmd.q] <= cmd.id;
		end else if (cmd.shift) begin
			slot_q[cmd.q] <= nb_data;
		end
	end

endmodule

### rtl/multi_queue_id_manager.sv
// ----------------------------------------------------------------------------
// multi_queue_id_manager
// Several ordered id queues kept in a row of cells with delete-and-compact.
// ----------------------------------------------------------------------------
// usage
//   cmd: one beat per command (operation, ident, queue_sel). enqueue appends
//     at the tail, remove deletes the first match and closes the gap, find
//     reports the position of the first match and whether it is the head
//   res: one beat per command (status, found, position, at_head,
//     queue_length), in command order
//   timing: a command is taken in the idle state, all cells compare in the
//     compare state into a registered match vector, and the update state picks
//     the first match, updates the cells and loads the result register.
//     cmd.ready is high only in the idle state, so the next command waits until
//     the update state has finished the previous one
//   stall: a result waiting in the output register does not block the next
//     command or its compare; only the update cycle waits for the slot
//   reset: arst_n clears all queue lengths and the control state; slot
//     contents are not cleared, a slot is only read below its queue length
//   bad queue number: status bad queue, other fields zero, nothing changes
// ----------------------------------------------------------------------------
module multi_queue_id_manager import mqim_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mqim_cmd_if.sink  cmd,
	mqim_res_if.source res
);

	// sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_RES  = 2'd2;

	logic [1:0]         state_q;
	logic [OP_W-1:0]    op_q;
	logic [ID_BITS-1:0] id_q;
	logic [QIDX_W-1:0]  qidx_q;
	logic               good_q;
	logic [CNT_W-1:0]   len_q [NUM_QUEUES];
	logic [QUEUE_DEPTH-1:0] match_q;

	// result register
	logic              res_valid_q;
	logic [STAT_W-1:0] status_q;
	logic              found_q;
	logic [POS_W-1:0]  position_q;
	logic              at_head_q;
	logic [LEN_W-1:0]  queue_length_q;

	logic                   accept;
	logic                   cmd_good;
	logic                   advance;
	logic [CNT_W-1:0]       cur_len;
	logic [QUEUE_DEPTH-1:0] live;
	logic [QUEUE_DEPTH-1:0] raw_match;
	logic [QUEUE_DEPTH-1:0] first;
	logic [QUEUE_DEPTH-1:0] ge_first;
	logic                   hit;
	logic [PIDX_W-1:0]      pos;
	logic                   is_enq;
	logic                   is_rem;
	logic                   is_find;
	logic                   full;

	logic [STAT_W-1:0] nxt_status;
	logic              nxt_found;
	logic [CNT_W-1:0]  nxt_len;

	mqim_cell_cmd_t     cell_cmd  [QUEUE_DEPTH];
	logic [ID_BITS-1:0] cell_data [QUEUE_DEPTH];

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_good  = ({1'b0, cmd.queue_sel} < 3'(NUM_QUEUES));

	assign cur_len = len_q[qidx_q];
	assign is_enq  = (op_q == OP_ENQ);
	assign is_rem  = (op_q == OP_REM);
	assign is_find = (op_q == OP_FIND);
	assign full    = (cur_len == CNT_W'(QUEUE_DEPTH));
	assign advance = (state_q == S_RES) && (!res_valid_q || res.ready);

	// first match: lowest set bit, and the mask of cells at or after it
	assign hit      = |match_q;
	assign first    = match_q & (~match_q + QUEUE_DEPTH'(1));
	assign ge_first = ~(first - QUEUE_DEPTH'(1));

	always_comb begin
		pos = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (first[i]) begin
				pos = pos | PIDX_W'(i);
			end
		end
	end

	// row of cells, each takes its right neighbor's slot on a compaction
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [ID_BITS-1:0] nb;

		if (i + 1 < QUEUE_DEPTH) begin : g_nb
			assign nb = cell_data[i+1];
		end else begin : g_end
			assign nb = '0;
		end

		assign live[i]            = (CNT_W'(i) < cur_len);
		assign cell_cmd[i].q      = qidx_q;
		assign cell_cmd[i].id     = id_q;
		assign cell_cmd[i].load   = advance && good_q && is_enq && !full &&
			(CNT_W'(i) == cur_len);
		// gap closes from the match up to the last live slot
		assign cell_cmd[i].shift  = advance && good_q && is_rem && hit &&
			ge_first[i] && (CNT_W'(i + 1) < cur_len);

		mqim_cell u_cell (
			.clk     (clk),
			.cmd     (cell_cmd[i]),
			.nb_data (nb),
			.data    (cell_data[i]),
			.match   (raw_match[i])
		);
	end

	// outcome of the command in the update cycle
	always_comb begin
		nxt_status = STAT_OK;
		nxt_found  = 1'b0;
		nxt_len    = cur_len;
		if (!good_q) begin
			nxt_status = STAT_BADQ;
			nxt_len    = '0;
		end else if (is_enq) begin
			if (full) begin
				nxt_status = STAT_FULL;
			end else begin
				nxt_len = cur_len + CNT_W'(1);
			end
		end else if (is_rem || is_find) begin
			if (!hit) begin
				nxt_status = STAT_MISSING;
			end else begin
				nxt_found = 1'b1;
				if (is_rem) begin
					nxt_len = cur_len - CNT_W'(1);
				end
			end
		end
	end

	// sequencer and command capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_RES;
				end
				S_RES: begin
					if (advance) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd.operation;
			id_q   <= ID_BITS'(cmd.ident);
			good_q <= cmd_good;
			qidx_q <= cmd_good ? QIDX_W'(cmd.queue_sel) : '0;
		end
		if (state_q == S_CMP) begin
			match_q <= raw_match & live;
		end
	end

	// queue lengths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_QUEUES; k++) begin
				len_q[k] <= '0;
			end
		end else if (advance && good_q) begin
			len_q[qidx_q] <= nxt_len;
		end
	end

	// result register: loads when empty or while the previous beat leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q       <= nxt_status;
			found_q        <= nxt_found;
			position_q     <= nxt_found ? POS_W'(pos) : '0;
			at_head_q      <= nxt_found && (pos == '0);
			queue_length_q <= LEN_W'(nxt_len);
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = status_q;
	assign res.found        = found_q;
	assign res.position     = position_q;
	assign res.at_head      = at_head_q;
	assign res.queue_length = queue_length_q;

	// a new result beat only comes out of the update cycle
	a_res_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_RES)
		else $error("result beat raised outside the update cycle");

	// head flag only with a match at position zero
	a_head_found: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && at_head_q |-> found_q && (position_q == '0))
		else $error("at_head without a match at the head");

	// a match never comes with an error status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && found_q |-> status_q == STAT_OK)
		else $error("found reported with error status");

	// lengths stay within the queue capacity
	for (genvar k = 0; k < NUM_QUEUES; k++) begin : g_len_chk
		a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
			len_q[k] <= CNT_W'(QUEUE_DEPTH))
			else $error("queue length beyond capacity");
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the multi-queue id manager beat by beat against a shadow copy of the
// queues: a directed table of corner cases, then random phases that fill,
// drain and search the queues under bursty commands and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
	import mqim_pkg::*;

	// the unused operation code acts as a no-op on the target queue
	localparam logic [OP_W-1:0]   OP_NOP   = 2'd3;
	// first queue number past the configured queues
	localparam logic [QSEL_W-1:0] QSEL_BAD = QSEL_W'(NUM_QUEUES);

	localparam int STALL_LIMIT = 4000; // cycles with no beat on either channel
	localparam int SETTLE      = 12;   // quiet cycles after the last result
	localparam int HOLD_AT     = 500;  // result beats seen before the long hold-off
	localparam int HOLD_CYCLES = 150;

	// random phases: enqueue and remove shares in percent, beats per phase
	localparam int NUM_PHASES = 6;
	localparam int PHASE_ENQ   [NUM_PHASES] = '{90, 20, 50, 85, 10, 45};
	localparam int PHASE_REM   [NUM_PHASES] = '{5, 60, 25, 10, 75, 30};
	localparam int PHASE_BEATS [NUM_PHASES] = '{300, 200, 250, 250, 250, 150};

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [IDENT_W-1:0] ident;
		logic [QSEL_W-1:0]  queue_sel;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              found;
		logic [POS_W-1:0]  position;
		logic              at_head;
		logic [LEN_W-1:0]  queue_length;
	} reply_t;

	// one line of the directed table; typed rows carry their own reply
	typedef struct packed {
		cmd_t   cmd;
		logic   typed;
		reply_t reply;
	} row_t;

	localparam int NUM_ROWS = 25;
	localparam row_t DIRECTED [NUM_ROWS] = '{
		// empty queues never match
		{OP_FIND, 22'h000000, 2'd0,     1'b1, STAT_MISSING, 1'b0, 6'd0, 1'b0, 7'd0},
		{OP_REM,  22'h000005, 2'd1,     1'b1, STAT_MISSING, 1'b0, 6'd0, 1'b0, 7'd0},
		// bad queue number on every operation
		{OP_ENQ,  22'h3fffff, QSEL_BAD, 1'b1, STAT_BADQ,    1'b0, 6'd0, 1'b0, 7'd0},
		{OP_FIND, 22'h000000, QSEL_BAD, 1'b1, STAT_BADQ,    1'b0, 6'd0, 1'b0, 7'd0},
		{OP_REM,  22'h000000, QSEL_BAD, 1'b1, STAT_BADQ,    1'b0, 6'd0, 1'b0, 7'd0},
		{OP_NOP,  22'h000000, 2'd0,     1'b1, STAT_OK,      1'b0, 6'd0, 1'b0, 7'd0},
		{OP_NOP,  22'h3fffff, QSEL_BAD, 1'b1, STAT_BADQ,    1'b0, 6'd0, 1'b0, 7'd0},
		// extreme ids, head and non-head hits
		{OP_ENQ,  22'h000000, 2'd0,     1'b1, STAT_OK,      1'b0, 6'd0, 1'b0, 7'd1},
		{OP_ENQ,  22'h3fffff, 2'd0,     1'b1, STAT_OK,      1'b0, 6'd0, 1'b0, 7'd2},
		{OP_FIND, 22'h000000, 2'd0,     1'b1, STAT_OK,      1'b1, 6'd0, 1'b1, 7'd2},
		{OP_FIND, 22'h3fffff, 2'd0,     1'b1, STAT_OK,      1'b1, 6'd1, 1'b0, 7'd2},
		// duplicate id: remove takes the first, compaction moves the rest
		{OP_ENQ,  22'h000000, 2'd0,     1'b0, 17'd0},
		{OP_NOP,  22'h000000, 2'd0,     1'b0, 17'd0},
		{OP_REM,  22'h000000, 2'd0,     1'b0, 17'd0},
		{OP_FIND, 22'h000000, 2'd0,     1'b0, 17'd0},
		// id held only by another queue
		{OP_FIND, 22'h000000, 2'd1,     1'b1, STAT_MISSING, 1'b0, 6'd0, 1'b0, 7'd0},
		// removal in the middle and at the head, then a stale slot
		{OP_ENQ,  22'h2aaaaa, 2'd2,     1'b0, 17'd0},
		{OP_ENQ,  22'h155555, 2'd2,     1'b0, 17'd0},
		{OP_ENQ,  22'h2aaaaa, 2'd2,     1'b0, 17'd0},
		{OP_REM,  22'h155555, 2'd2,     1'b0, 17'd0},
		{OP_FIND, 22'h155555, 2'd2,     1'b0, 17'd0},
		{OP_REM,  22'h2aaaaa, 2'd2,     1'b0, 17'd0},
		{OP_REM,  22'h2aaaaa, 2'd2,     1'b0, 17'd0},
		{OP_FIND, 22'h2aaaaa, 2'd2,     1'b1, STAT_MISSING, 1'b0, 6'd0, 1'b0, 7'd0},
		{OP_REM,  22'h3fffff, 2'd0,     1'b1, STAT_OK,      1'b1, 6'd0, 1'b1, 7'd1}
	};

	logic clk;
	logic arst_n;

	mqim_cmd_if cmd ();
	mqim_res_if res ();

	multi_queue_id_manager u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	// shadow copy of the queues, advanced on every accepted command beat
	logic [ID_BITS-1:0] shadow_ids [NUM_QUEUES][QUEUE_DEPTH];
	int unsigned        shadow_len [NUM_QUEUES];

	reply_t      due_replies [$];  // predicted replies, oldest first
	int unsigned error_count;
	int unsigned reply_beats;
	int unsigned quiet_cycles;
	int unsigned burst_left;
	bit          holding_off;      // receiver is in its long hold-off

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// works out the reply to one command and updates the shadow queues
	function automatic reply_t apply_queue_cmd(cmd_t c);
		reply_t             r;
		int                 qi;
		int                 n;
		int                 hit;
		logic [ID_BITS-1:0] key;
		r = '0;
		if (c.queue_sel >= NUM_QUEUES) begin
			r.status = STAT_BADQ;
			return r;
		end
		qi  = c.queue_sel;
		n   = shadow_len[qi];
		key = c.ident[ID_BITS-1:0];
		r.status       = STAT_OK;
		r.queue_length = LEN_W'(n);
		case (c.op)
			OP_ENQ: begin
				if (n >= QUEUE_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					shadow_ids[qi][n] = key;
					shadow_len[qi]    = n + 1;
					r.queue_length    = LEN_W'(n + 1);
				end
			end
			OP_REM, OP_FIND: begin
				// only slots below the length take part in the search
				hit = -1;
				for (int i = 0; i < n; i++)
					if (hit < 0 && shadow_ids[qi][i] == key)
						hit = i;
				if (hit < 0) begin
					r.status = STAT_MISSING;
				end else begin
					if (c.op == OP_REM) begin
						// close the gap toward the head
						for (int j = hit; j + 1 < n; j++)
							shadow_ids[qi][j] = shadow_ids[qi][j + 1];
						shadow_len[qi] = n - 1;
						r.queue_length = LEN_W'(n - 1);
					end
					r.found    = 1'b1;
					r.position = POS_W'(hit);
					r.at_head  = (hit == 0);
				end
			end
			default: ; // no-op leaves the queue alone
		endcase
		return r;
	endfunction

	task automatic report_field(string name, int unsigned want, int unsigned got);
		error_count++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
	endtask

	task automatic compare_reply(reply_t want, reply_t got);
		if (got.status !== want.status)
			report_field("status", want.status, got.status);
		if (got.found !== want.found)
			report_field("found", want.found, got.found);
		if (got.position !== want.position)
			report_field("position", want.position, got.position);
		if (got.at_head !== want.at_head)
			report_field("at_head", want.at_head, got.at_head);
		if (got.queue_length !== want.queue_length)
			report_field("queue_length", want.queue_length, got.queue_length);
	endtask

	// offers one command beat; bursts of random length end in a random gap
	task automatic send_cmd(cmd_t c, logic typed, reply_t typed_reply);
		int     gap;
		reply_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			// no gaps while the receiver holds off, so the block backs up
			if (holding_off || $urandom_range(0, 3) == 0)
				gap = 0;
			else
				gap = $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				cmd.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		cmd.valid     <= 1'b1;
		cmd.operation <= c.op;
		cmd.ident     <= c.ident;
		cmd.queue_sel <= c.queue_sel;
		do @(posedge clk); while (!cmd.ready);
		predicted = apply_queue_cmd(c);
		due_replies.push_back(typed ? typed_reply : predicted);
	endtask

	// sender pause until every predicted reply has come back
	task automatic wait_all_returned();
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (due_replies.size() != 0) @(posedge clk);
		burst_left = 0;
	endtask

	// result monitor: every beat is matched against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			reply_beats++;
			if (due_replies.size() == 0) begin
				error_count++;
				$display("%0t: result beat with nothing expected, got status %0d len %0d",
					$time, res.status, res.queue_length);
			end else begin
				compare_reply(due_replies.pop_front(),
					{res.status, res.found, res.position, res.at_head, res.queue_length});
			end
		end
	end

	// watchdog: counts cycles in which neither channel moves a beat
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= STALL_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// receiver: stall pattern that cycles through four modes, plus one long
	// hold-off once enough replies have gone by
	initial begin : receiver
		int unsigned cyc;
		bit          hold_done;
		bit          rdy;
		cyc         = 0;
		hold_done   = 1'b0;
		holding_off = 1'b0;
		res.ready   = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (!hold_done && reply_beats >= HOLD_AT) begin
				holding_off = 1'b1;
				res.ready  <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				holding_off = 1'b0;
				hold_done   = 1'b1;
			end else begin
				case ((cyc / 53) % 4)
					0: rdy = 1'b1;                          // no stalls
					1: rdy = 1'($urandom_range(0, 1));      // coin flip
					2: rdy = ($urandom_range(0, 3) == 0);   // mostly stalled
					default: rdy = ((cyc % 7) > 2);         // fixed rhythm
				endcase
				res.ready <= rdy;
			end
		end
	end

	initial begin : stimulus
		cmd_t c;
		int   r;
		int   qi;
		burst_left   = 0;
		foreach (shadow_len[i])
			shadow_len[i] = 0;

		cmd.valid     = 1'b0;
		cmd.operation = OP_ENQ;
		cmd.ident     = '0;
		cmd.queue_sel = '0;
		arst_n        = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (int i = 0; i < NUM_ROWS; i++)
			send_cmd(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].reply);
		wait_all_returned();

		// random phases: fill, drain and mixed traffic
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			for (int k = 0; k < PHASE_BEATS[ph]; k++) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					c.op = OP_NOP;
				else if (r < 3 + PHASE_ENQ[ph])
					c.op = OP_ENQ;
				else if (r < 3 + PHASE_ENQ[ph] + PHASE_REM[ph])
					c.op = OP_REM;
				else
					c.op = OP_FIND;

				// an occasional bad queue number
				if ($urandom_range(0, 99) < 6)
					c.queue_sel = QSEL_BAD;
				else
					c.queue_sel = QSEL_W'($urandom_range(0, NUM_QUEUES - 1));

				// ids: mostly ones the queue holds, some from a small pool
				// so duplicates pile up, the rest fully random
				r  = $urandom_range(0, 99);
				qi = c.queue_sel;
				if (r < 60 && qi < NUM_QUEUES && shadow_len[qi] > 0)
					c.ident = shadow_ids[qi][$urandom_range(0, shadow_len[qi] - 1)];
				else if (r < 80)
					c.ident = IDENT_W'($urandom_range(0, 7));
				else
					c.ident = IDENT_W'($urandom());

				send_cmd(c, 1'b0, '0);
			end
			wait_all_returned();
		end

		repeat (SETTLE) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
rtl/mqim_pkg.sv
rtl/mqim_cmd_if.sv
rtl/mqim_res_if.sv
rtl/mqim_cell.sv
rtl/multi_queue_id_manager.sv
tb/testbench.sv
